// ===== rtl/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, codes and helpers for the stepper pulse ramp generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_SET    = 2'd2
  } func_t;

  localparam logic [15:0] TIMER_TOP   = 16'hFFFF;
  localparam logic [15:0] RESET_FREQ  = 16'd5000;
  localparam logic [11:0] RESET_HOLD  = 12'd100;
  localparam logic [32:0] DIV50_RECIP = 33'd83887;
  localparam int          DIV50_SHIFT = 22;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load_timer;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

  // floor(x / 50) by reciprocal multiply, exact for all 16-bit x
  function automatic logic [11:0] div50(input logic [15:0] x);
    logic [33:0] prod;
    prod = {18'd0, x} * {1'b0, DIV50_RECIP};
    return prod[DIV50_SHIFT +: 12];
  endfunction

endpackage

// ===== rtl/srg_div.sv =====
// ----------------------------------------------------------------------------
// srg_div
// Restoring divider: timer preload 65535 - CLOCK_K*1000/divisor, floored at 0.
// ----------------------------------------------------------------------------
module srg_div #(
  parameter int unsigned CLOCK_K = 16000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] preload
);

  localparam int unsigned DIVIDEND = CLOCK_K * 1000;
  localparam int          DW       = $clog2(DIVIDEND + 1);
  localparam int          CW       = $clog2(DW + 1);

  logic [16:0]   rem;
  logic [DW-1:0] quo;
  logic [15:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          zero;

  logic [16:0]   rem_sh;
  logic          ge;
  logic [16:0]   rem_next;
  logic [31:0]   q32;
  logic          sat;

  assign rem_sh   = {rem[15:0], quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= DW'(DIVIDEND);
      dvs  <= divisor;
      zero <= (divisor == 16'd0);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign q32     = 32'(quo);
  assign sat     = zero || (q32 > 32'd65535);
  assign preload = sat ? 16'd0 : (srg_pkg::TIMER_TOP - q32[15:0]);
  assign done    = !busy;

endmodule

// ===== rtl/srg_datapath.sv =====
// ----------------------------------------------------------------------------
// srg_datapath
// Timer, hold counter, frequency ramp, pulse and result registers.
// ----------------------------------------------------------------------------
module srg_datapath #(
  parameter int unsigned CLOCK_K   = 16000,
  parameter int unsigned RAMP_STEP = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  srg_pkg::cmd_t cmd,
  output srg_pkg::sts_t sts,
  input  logic [1:0]    func,
  input  logic [15:0]   new_frequency,
  output logic          pulse_level,
  output logic [15:0]   current_frequency,
  output logic          at_target,
  output logic          overflowed
);

  localparam logic [15:0] RESET_TIMER = 16'(65535 - (CLOCK_K * 1000) / 5000);
  localparam logic [15:0] STEP_MAX    = 16'(RAMP_STEP);

  logic [1:0]  fn;
  logic [15:0] nf;
  logic [15:0] timer_count;
  logic [15:0] frequency_now;
  logic [15:0] frequency_target;
  logic [11:0] hold_count;
  logic        pulse_reg;
  logic        ovf;

  logic        is_tick;
  logic        is_top;
  logic        is_set;
  logic [11:0] hold_dec;
  logic        hold_out;
  logic [15:0] diff;
  logic [15:0] step;
  logic [15:0] ramped;
  logic [15:0] frequency_now_next;
  logic [11:0] hold_quot;
  logic        div_done;
  logic [15:0] preload;

  assign is_tick  = (fn == srg_pkg::FUNC_TICK);
  assign is_set   = (fn == srg_pkg::FUNC_SET);
  assign is_top   = (timer_count == srg_pkg::TIMER_TOP);
  assign hold_dec = hold_count - 12'd1;
  assign hold_out = hold_dec[11] || (hold_dec == 12'd0);

  assign diff   = (frequency_now > frequency_target) ? (frequency_now - frequency_target)
                                                     : (frequency_target - frequency_now);
  assign step   = (diff < STEP_MAX) ? diff : STEP_MAX;
  assign ramped = (frequency_now < frequency_target) ? (frequency_now + step)
                                                     : (frequency_now - step);

  assign hold_quot = srg_pkg::div50(is_set ? nf : frequency_now);

  always_comb begin
    frequency_now_next = frequency_now;
    if (is_set) begin
      frequency_now_next = nf;
    end else if (is_tick && is_top && hold_out) begin
      frequency_now_next = ramped;
    end
  end

  assign sts.need_div = (is_tick && is_top) || is_set;
  assign sts.div_done = div_done;

  srg_div #(
    .CLOCK_K(CLOCK_K)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.execute && sts.need_div),
    .divisor(frequency_now_next),
    .done   (div_done),
    .preload(preload)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fn <= func;
      nf <= new_frequency;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count      <= RESET_TIMER;
      frequency_now    <= srg_pkg::RESET_FREQ;
      frequency_target <= srg_pkg::RESET_FREQ;
      hold_count       <= srg_pkg::RESET_HOLD;
      pulse_reg        <= 1'b1;
      ovf              <= 1'b0;
    end else if (cmd.load_timer) begin
      timer_count <= preload;
    end else if (cmd.execute) begin
      ovf           <= is_tick && is_top;
      frequency_now <= frequency_now_next;
      case (fn)
        srg_pkg::FUNC_TICK: begin
          if (is_top) begin
            hold_count <= hold_out ? hold_quot : hold_dec;
            pulse_reg  <= !pulse_reg;
          end else begin
            timer_count <= timer_count + 16'd1;
          end
        end
        srg_pkg::FUNC_TARGET: begin
          frequency_target <= nf;
        end
        srg_pkg::FUNC_SET: begin
          frequency_target <= nf;
          hold_count       <= hold_quot;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pulse_level       <= pulse_reg;
      current_frequency <= frequency_now;
      at_target         <= (frequency_now == frequency_target);
      overflowed        <= ovf;
    end
  end

endmodule

// ===== rtl/srg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: capture item, execute, wait on divider, deliver result.
// ----------------------------------------------------------------------------
module srg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output srg_pkg::cmd_t cmd,
  input  srg_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.execute    = 1'b0;
    cmd.load_timer = 1'b0;
    cmd.load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = sts.need_div ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.load_timer = 1'b1;
          state_next     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/stepper_pulse_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_generator
// Step-pulse generator with a linear frequency ramp toward a target.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   func, new_frequency
//   out      source     out_valid / out_ready pulse_level, current_frequency,
//                                             at_target, overflowed
//
// A plain tick or target write goes through capture, execute and result.
// A tick that overflows the timer, or a frequency set, also waits on the
// bit-serial preload divider, whose quotient is DW = clog2(CLOCK_K*1000 + 1)
// bits wide (24 by default). One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
// Reset is synchronous and loads the 5000 Hz operating point.
// ----------------------------------------------------------------------------
module stepper_pulse_ramp_generator #(
  parameter int unsigned CLOCK_K   = 16000,
  parameter int unsigned RAMP_STEP = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] new_frequency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pulse_level,
  output logic [15:0] current_frequency,
  output logic        at_target,
  output logic        overflowed
);

  srg_pkg::cmd_t cmd;
  srg_pkg::sts_t sts;

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  srg_datapath #(
    .CLOCK_K  (CLOCK_K),
    .RAMP_STEP(RAMP_STEP)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .func             (func),
    .new_frequency    (new_frequency),
    .pulse_level      (pulse_level),
    .current_frequency(current_frequency),
    .at_target        (at_target),
    .overflowed       (overflowed)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted item did not block the input");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> sts.div_done)
    else $error("divider busy while idle");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an unaccepted item");

endmodule
